/* rtl/lsdc_pkg.sv */
package lsdc_pkg;

   // Sizing of the sieve
   localparam int unsigned MAX_LIMIT   = 65536;
   localparam int unsigned PRIME_SLOTS = 8192;

   localparam int unsigned NUM_W      = 17;   // number, limit and factor fields
   localparam int unsigned CNT_W      = 8;    // divisor count field
   localparam int unsigned EXP_W      = 5;    // exponent of the least factor
   localparam int unsigned DIV_W      = EXP_W + 1;   // exponent + 1, exponent + 2
   localparam int unsigned DIV_STEP_W = $clog2(CNT_W + 1);
   localparam int unsigned TAB_DEPTH  = MAX_LIMIT + 1;
   localparam int unsigned TAB_AW     = $clog2(TAB_DEPTH);
   localparam int unsigned PRIME_AW   = $clog2(PRIME_SLOTS);
   localparam int unsigned TOTAL_W    = $clog2(PRIME_SLOTS + 1);
   localparam int unsigned PROD_W     = 2 * NUM_W;
   localparam int unsigned SCALE_W    = CNT_W + DIV_W;

   localparam logic [CNT_W-1:0] CNT_SAT        = '1;
   localparam logic [CNT_W-1:0] PRIME_DIVISORS = CNT_W'(2);
   localparam logic [EXP_W-1:0] PRIME_EXPONENT = EXP_W'(1);

   // Register map (word index)
   localparam logic REG_LIMIT = 1'b0;
   localparam logic [NUM_W-1:0] LIMIT_RESET = NUM_W'(65536);

   // One word of the per-number table
   typedef struct packed {
      logic [NUM_W-1:0] lf;
      logic [EXP_W-1:0] exp;
      logic [CNT_W-1:0] cnt;
   } tab_entry_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* rtl/linear_sieve_divisor_count.sv */
// Linear (Euler) sieve with divisor counts. Feed the numbers 2, 3, 4, ... up to
// the limit register, one beat each; every request beat returns one response beat
// with the number, its divisor count, its least prime factor, a prime flag and a
// reject flag. A number out of sequence or above min(limit, 65536) is rejected
// with divisor count, least factor and prime flag zero and changes nothing. After
// reset the block sweeps its 65537-entry factor table to zero, one entry a cycle,
// so req_tready stays low until the sweep is done; configuration writes are taken
// throughout. Each number then takes one table read, a serial division of the
// divisor count by exponent+1, one scaling multiply, and for each stored prime
// walked a prime list read, a product multiply, and a compare and table write on
// the single table write port. The next request is taken while a result still
// waits in the output register. Divisor counts saturate at 255; with the
// 8192-entry prime list full, later primes are reported but not used to mark.
module linear_sieve_divisor_count (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [16:0] number
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [16:0] number_out, [24:17] divisor_count,
                                    // [41:25] least_factor
   output logic [1:0]  rsp_tuser,   // [0] is_prime, [1] bad_request
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned NW = lsdc_pkg::NUM_W;
   localparam int unsigned CW = lsdc_pkg::CNT_W;
   localparam int unsigned EW = lsdc_pkg::EXP_W;
   localparam int unsigned DW = lsdc_pkg::DIV_W;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_LOOK     = 4'd2;
   localparam logic [3:0] S_DIV_GO   = 4'd3;
   localparam logic [3:0] S_DIV_WAIT = 4'd4;
   localparam logic [3:0] S_SCALE    = 4'd5;
   localparam logic [3:0] S_WALK_RD  = 4'd6;
   localparam logic [3:0] S_WALK_P   = 4'd7;
   localparam logic [3:0] S_WALK_CMP = 4'd8;
   localparam logic [3:0] S_FIN      = 4'd9;

   localparam logic [NW-1:0] MAX_NUM = NW'(lsdc_pkg::MAX_LIMIT);

   // memories
   lsdc_pkg::tab_entry_type tab_mem [lsdc_pkg::TAB_DEPTH];
   logic [NW-1:0]           prime_mem [lsdc_pkg::PRIME_SLOTS];

   lsdc_pkg::tab_entry_type tab_rd_ff;
   logic [NW-1:0]           prime_rd_ff;

   logic                          tab_we;
   logic [lsdc_pkg::TAB_AW-1:0]   tab_waddr;
   lsdc_pkg::tab_entry_type       tab_wdata;
   logic                          prime_we;

   // control and datapath registers
   logic [3:0]                    state_ff, state_in;
   logic [lsdc_pkg::TAB_AW-1:0]   clr_ff, clr_in;
   logic [NW-1:0]                 limit_ff, limit_in;
   logic [NW-1:0]                 expect_ff, expect_in;
   logic [lsdc_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [lsdc_pkg::TOTAL_W-1:0]  idx_ff, idx_in;
   logic [NW-1:0]                 num_ff, num_in;
   logic                          bad_ff, bad_in;
   logic [NW-1:0]                 lf_ff, lf_in;
   logic [EW-1:0]                 exp_ff, exp_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [CW-1:0]                 same_ff, same_in;
   logic [CW-1:0]                 dbl_ff, dbl_in;
   logic [NW-1:0]                 p_ff, p_in;
   logic [lsdc_pkg::PROD_W-1:0]   prod_ff, prod_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0]                 rsp_num_ff, rsp_num_in;
   logic [CW-1:0]                 rsp_cnt_ff, rsp_cnt_in;
   logic [NW-1:0]                 rsp_lf_ff, rsp_lf_in;
   logic                          rsp_prime_ff, rsp_prime_in;
   logic                          rsp_bad_ff, rsp_bad_in;

   logic [NW-1:0]                 req_number;
   logic [NW-1:0]                 eff_limit;
   logic                          req_fire;
   logic                          csr_write;
   lsdc_pkg::div_req_type         div_req;
   lsdc_pkg::div_rsp_type         div_rsp;
   logic [lsdc_pkg::SCALE_W-1:0]  scaled;
   logic [CW:0]                   doubled;
   logic                          same_lf;

   lsdc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_number = req_tdata[NW-1:0];
   assign eff_limit  = (limit_ff > MAX_NUM) ? MAX_NUM : limit_ff;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;

   // configuration port: zero-wait, write on the access cycle
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == lsdc_pkg::REG_LIMIT) ? 32'(limit_ff) : '0;
   assign limit_in   = (csr_write && csr_paddr[2] == lsdc_pkg::REG_LIMIT)
                       ? csr_pwdata[NW-1:0] : limit_ff;

   assign same_lf = (p_ff == lf_ff);
   assign scaled  = lsdc_pkg::SCALE_W'(div_rsp.quotient) *
                    lsdc_pkg::SCALE_W'(DW'(exp_ff) + DW'(2));
   assign doubled = {cnt_ff, 1'b0};

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      expect_in    = expect_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      num_in       = num_ff;
      bad_in       = bad_ff;
      lf_in        = lf_ff;
      exp_in       = exp_ff;
      cnt_in       = cnt_ff;
      same_in      = same_ff;
      dbl_in       = dbl_ff;
      p_in         = p_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_num_in   = rsp_num_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_lf_in    = rsp_lf_ff;
      rsp_prime_in = rsp_prime_ff;
      rsp_bad_in   = rsp_bad_ff;
      tab_we       = 1'b0;
      tab_waddr    = clr_ff;
      tab_wdata    = '0;
      prime_we     = 1'b0;
      div_req      = '0;
      div_req.dividend = cnt_ff;
      div_req.divisor  = DW'(exp_ff) + DW'(1);

      unique case (state_ff)
         S_CLEAR: begin
            // sweep the table to all zero, one entry a cycle
            tab_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == lsdc_pkg::TAB_AW'(lsdc_pkg::MAX_LIMIT)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               num_in = req_number;
               bad_in = (req_number != expect_ff) || (req_number > eff_limit) ||
                        (req_number < NW'(2));
               // the table read of the number is launched in this cycle
               state_in = bad_in ? S_FIN : S_LOOK;
            end
         end
         S_LOOK: begin
            if (tab_rd_ff.lf == '0) begin
               // unmarked: a new prime
               lf_in     = num_ff;
               exp_in    = lsdc_pkg::PRIME_EXPONENT;
               cnt_in    = lsdc_pkg::PRIME_DIVISORS;
               tab_we    = 1'b1;
               tab_waddr = lsdc_pkg::TAB_AW'(num_ff);
               tab_wdata = '{lf: num_ff, exp: lsdc_pkg::PRIME_EXPONENT,
                             cnt: lsdc_pkg::PRIME_DIVISORS};
               if (total_ff < lsdc_pkg::TOTAL_W'(lsdc_pkg::PRIME_SLOTS)) begin
                  prime_we = 1'b1;
                  total_in = total_ff + 1'b1;
               end
            end else begin
               lf_in  = tab_rd_ff.lf;
               exp_in = tab_rd_ff.exp;
               cnt_in = tab_rd_ff.cnt;
            end
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            div_req.start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            // count for the same least factor: d/(e+1)*(e+2); for a new one: 2*d
            same_in  = (scaled > lsdc_pkg::SCALE_W'(lsdc_pkg::CNT_SAT))
                       ? lsdc_pkg::CNT_SAT : scaled[CW-1:0];
            dbl_in   = doubled[CW] ? lsdc_pkg::CNT_SAT : doubled[CW-1:0];
            idx_in   = '0;
            state_in = S_WALK_RD;
         end
         S_WALK_RD: begin
            // the prime list read at idx is launched in this cycle
            state_in = (idx_ff < total_ff) ? S_WALK_P : S_FIN;
         end
         S_WALK_P: begin
            p_in     = prime_rd_ff;
            prod_in  = num_ff * prime_rd_ff;
            state_in = S_WALK_CMP;
         end
         S_WALK_CMP: begin
            if ((p_ff > lf_ff) || (prod_ff > lsdc_pkg::PROD_W'(eff_limit))) begin
               state_in = S_FIN;
            end else begin
               tab_we    = 1'b1;
               tab_waddr = prod_ff[lsdc_pkg::TAB_AW-1:0];
               tab_wdata = '{lf: p_ff,
                             exp: same_lf ? exp_ff + 1'b1 : lsdc_pkg::PRIME_EXPONENT,
                             cnt: same_lf ? same_ff : dbl_ff};
               idx_in    = idx_ff + 1'b1;
               state_in  = S_WALK_RD;
            end
         end
         S_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = num_ff;
               rsp_bad_in   = bad_ff;
               rsp_cnt_in   = bad_ff ? '0 : cnt_ff;
               rsp_lf_in    = bad_ff ? '0 : lf_ff;
               rsp_prime_in = ~bad_ff & (lf_ff == num_ff);
               if (!bad_ff) begin
                  expect_in = num_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         limit_ff     <= lsdc_pkg::LIMIT_RESET;
         expect_ff    <= NW'(2);
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         limit_ff     <= limit_in;
         expect_ff    <= expect_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      num_ff       <= num_in;
      bad_ff       <= bad_in;
      lf_ff        <= lf_in;
      exp_ff       <= exp_in;
      cnt_ff       <= cnt_in;
      same_ff      <= same_in;
      dbl_ff       <= dbl_in;
      p_ff         <= p_in;
      prod_ff      <= prod_in;
      rsp_num_ff   <= rsp_num_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_lf_ff    <= rsp_lf_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   // factor table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[tab_waddr] <= tab_wdata;
      end
      tab_rd_ff <= tab_mem[req_number[lsdc_pkg::TAB_AW-1:0]];
   end

   // prime list: appended in order, read by the walk index
   always_ff @(posedge clock) begin
      if (prime_we) begin
         prime_mem[total_ff[lsdc_pkg::PRIME_AW-1:0]] <= num_ff;
      end
      prime_rd_ff <= prime_mem[idx_ff[lsdc_pkg::PRIME_AW-1:0]];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_lf_ff, rsp_cnt_ff, rsp_num_ff};
   assign rsp_tuser  = {rsp_bad_ff, rsp_prime_ff};

   // prime list never overfills
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= lsdc_pkg::TOTAL_W'(lsdc_pkg::PRIME_SLOTS))
      else $error("prime count above list size");

   // a walk only marks numbers above the one being handled
   a_mark_ahead: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK_CMP && tab_we) |-> (tab_waddr > lsdc_pkg::TAB_AW'(num_ff)))
      else $error("walk wrote at or below the current number");

   // a reported prime is its own least factor with two divisors
   a_prime_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_prime_ff) |->
         (rsp_cnt_ff == lsdc_pkg::PRIME_DIVISORS && rsp_lf_ff == rsp_num_ff))
      else $error("prime result inconsistent");

   // divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV_WAIT))
      else $error("divider done outside its wait state");

   // one number at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request taken while a number is in work");

endmodule

/* rtl/lsdc_div.sv */
// Restoring divider, one quotient bit a cycle.
module lsdc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  lsdc_pkg::div_req_type req,
   output lsdc_pkg::div_rsp_type rsp
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [lsdc_pkg::DIV_STEP_W-1:0]      step_ff, step_in;
   logic [lsdc_pkg::DIV_W-1:0]           rem_ff, rem_in;
   logic [lsdc_pkg::CNT_W-1:0]           quo_ff, quo_in;
   logic [lsdc_pkg::DIV_W-1:0]           dvs_ff, dvs_in;
   logic [lsdc_pkg::DIV_W:0]             trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[lsdc_pkg::CNT_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         step_in = lsdc_pkg::DIV_STEP_W'(lsdc_pkg::CNT_W);
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract where it fits
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = lsdc_pkg::DIV_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[lsdc_pkg::CNT_W-2:0], 1'b1};
         end else begin
            rem_in = trial[lsdc_pkg::DIV_W-1:0];
            quo_in = {quo_ff[lsdc_pkg::CNT_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == lsdc_pkg::DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
